// ===== src/smx_pkg.sv =====
// Shared types and constants for the swept square-wave mixer.
// Used by the register block, the tone datapath, the sweep multiplier and the top level.
// No dependencies.
package smx_pkg;

  // Phase accumulator fraction bits and sample counter bits
  localparam int PHASE_BITS = 32;
  localparam int COUNT_BITS = 20;

  // Register field widths
  localparam int STEP_W   = 40;
  localparam int FACTOR_W = 32;
  localparam int DUTY_W   = 17;
  localparam int VOL_W    = 15;
  localparam int LEN_W    = 20;
  localparam int SAMPLE_W = 16;

  // Configuration port: 64-bit data, registers on 8-byte strides
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  // Register reset values
  localparam logic [STEP_W-1:0]   START_STEP_RST   = '0;
  localparam logic [FACTOR_W-1:0] SWEEP_FACTOR_RST = 32'h4000_0000;
  localparam logic [DUTY_W-1:0]   DUTY_RST         = 17'd32768;
  localparam logic [VOL_W-1:0]    VOLUME_RST       = '0;
  localparam logic [LEN_W-1:0]    SAMPLE_COUNT_RST = '0;

  // Register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_START_STEP   = 3'd0,
    REG_SWEEP_FACTOR = 3'd1,
    REG_DUTY         = 3'd2,
    REG_VOLUME       = 3'd3,
    REG_SAMPLE_COUNT = 3'd4
  } reg_idx_t;

  // Configuration register set
  typedef struct packed {
    logic [STEP_W-1:0]   start_step;
    logic [FACTOR_W-1:0] sweep_factor;
    logic [DUTY_W-1:0]   duty;
    logic [VOL_W-1:0]    volume;
    logic [LEN_W-1:0]    sample_count;
  } cfg_t;

  // One input item
  typedef struct packed {
    logic                       restart;
    logic signed [SAMPLE_W-1:0] mix_in;
  } tick_t;

  // One result item
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mix_out;
    logic                       active;
    logic                       last;
  } result_t;

endpackage

// ===== src/smx_apb_regs.sv =====
// Configuration registers of the swept square-wave mixer behind an APB-style port.
// Depends on smx_pkg.
module smx_apb_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [smx_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [smx_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [smx_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output smx_pkg::cfg_t                    cfg
);
  import smx_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Write the addressed register, masked to its width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_step   <= START_STEP_RST;
      cfg.sweep_factor <= SWEEP_FACTOR_RST;
      cfg.duty         <= DUTY_RST;
      cfg.volume       <= VOLUME_RST;
      cfg.sample_count <= SAMPLE_COUNT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_START_STEP:   cfg.start_step   <= pwdata[STEP_W-1:0];
        REG_SWEEP_FACTOR: cfg.sweep_factor <= pwdata[FACTOR_W-1:0];
        REG_DUTY:         cfg.duty         <= pwdata[DUTY_W-1:0];
        REG_VOLUME:       cfg.volume       <= pwdata[VOL_W-1:0];
        REG_SAMPLE_COUNT: cfg.sample_count <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero-extended
  always_comb begin
    case (idx)
      REG_START_STEP:   prdata = APB_DATA_W'(cfg.start_step);
      REG_SWEEP_FACTOR: prdata = APB_DATA_W'(cfg.sweep_factor);
      REG_DUTY:         prdata = APB_DATA_W'(cfg.duty);
      REG_VOLUME:       prdata = APB_DATA_W'(cfg.volume);
      REG_SAMPLE_COUNT: prdata = APB_DATA_W'(cfg.sample_count);
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== src/smx_sweep_mul.sv =====
// Step sweep: UQ8.32 step times UQ2.30 factor, truncated, saturated to 40 bits.
// Built from two 20x32 partial products. Depends on smx_pkg.
module smx_sweep_mul (
  input  logic [smx_pkg::STEP_W-1:0]   step,
  input  logic [smx_pkg::FACTOR_W-1:0] factor,
  output logic [smx_pkg::STEP_W-1:0]   step_out
);
  import smx_pkg::*;

  localparam int HALF_W = STEP_W / 2;
  localparam int PROD_W = HALF_W + FACTOR_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int FRAC_W = 30;
  localparam int RES_W  = SUM_W - (FRAC_W - HALF_W);

  logic [PROD_W-1:0] prod_hi;
  logic [PROD_W-1:0] prod_lo;
  logic [SUM_W-1:0]  sum;
  logic [RES_W-1:0]  res;

  // Partial products on the upper and lower step halves
  assign prod_hi = PROD_W'(step[STEP_W-1:HALF_W]) * PROD_W'(factor);
  assign prod_lo = PROD_W'(step[HALF_W-1:0]) * PROD_W'(factor);

  // Align the low product, then drop the extra fraction bits down to the step's 32
  assign sum = SUM_W'(prod_hi) + SUM_W'(prod_lo >> HALF_W);
  assign res = RES_W'(sum >> (FRAC_W - HALF_W));

  // Saturate at the largest step
  assign step_out = (res[RES_W-1:STEP_W] != '0) ? '1 : res[STEP_W-1:0];

endmodule

// ===== src/smx_tone.sv =====
// Tone state and per-sample datapath: phase accumulate, duty compare, mix, sweep, count.
// Depends on smx_pkg and smx_sweep_mul.
module smx_tone (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  smx_pkg::tick_t   item,
  input  smx_pkg::cfg_t    cfg,
  output smx_pkg::result_t res,
  output logic             running
);
  import smx_pkg::*;

  logic [PHASE_BITS-1:0] phase;
  logic [STEP_W-1:0]     step_now;
  logic [COUNT_BITS-1:0] samples_done;

  logic [PHASE_BITS-1:0] phase_next;
  logic [STEP_W-1:0]     step_now_next;
  logic [COUNT_BITS-1:0] samples_done_next;
  logic                  running_next;

  logic [COUNT_BITS-1:0] limit;
  logic                  run0;
  logic [PHASE_BITS-1:0] phase0;
  logic [STEP_W-1:0]     step0;
  logic [COUNT_BITS-1:0] done0;
  logic [PHASE_BITS-1:0] phase_sum;
  logic [SAMPLE_W-1:0]   top16;
  logic [SAMPLE_W-1:0]   vol16;
  logic [SAMPLE_W-1:0]   level;
  logic [STEP_W-1:0]     step_swept;
  logic [COUNT_BITS-1:0] done_inc;
  logic                  is_last;

  assign limit = COUNT_BITS'(cfg.sample_count);

  // Restart reloads the tone before this sample is processed
  assign run0   = item.restart ? (limit != '0) : running;
  assign phase0 = item.restart ? '0 : phase;
  assign step0  = item.restart ? cfg.start_step : step_now;
  assign done0  = item.restart ? '0 : samples_done;

  // Advance the phase by the fraction bits of the step
  assign phase_sum = phase0 + step0[31 -: PHASE_BITS];
  assign top16     = phase_sum[PHASE_BITS-1 -: SAMPLE_W];

  // Low level below the duty point, high level at or above it
  assign vol16 = SAMPLE_W'(cfg.volume);
  assign level = ({1'b0, top16} < cfg.duty) ? (SAMPLE_W'(0) - vol16) : vol16;

  smx_sweep_mul u_sweep (
    .step     (step0),
    .factor   (cfg.sweep_factor),
    .step_out (step_swept)
  );

  // Count samples; the tone ends on wrap or on reaching the length
  assign done_inc = done0 + COUNT_BITS'(1);
  assign is_last  = (done_inc == '0) || (done_inc >= limit);

  // Result and next state
  always_comb begin
    if (run0) begin
      res.mix_out       = $signed(SAMPLE_W'($unsigned(item.mix_in) + level));
      res.active        = 1'b1;
      res.last          = is_last;
      phase_next        = phase_sum;
      step_now_next     = step_swept;
      samples_done_next = done_inc;
      running_next      = !is_last;
    end else begin
      res.mix_out       = item.mix_in;
      res.active        = 1'b0;
      res.last          = 1'b0;
      phase_next        = phase0;
      step_now_next     = step0;
      samples_done_next = done0;
      running_next      = 1'b0;
    end
  end

  // Commit state when the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= '0;
      step_now     <= '0;
      samples_done <= '0;
      running      <= 1'b0;
    end else if (advance) begin
      phase        <= phase_next;
      step_now     <= step_now_next;
      samples_done <= samples_done_next;
      running      <= running_next;
    end
  end

endmodule

// ===== src/swept_square_wave_mixer_unit.sv =====
// Top level of the swept square-wave mixer: stream ports, input and result registers.
// Depends on smx_pkg, smx_apb_regs and smx_tone.
//
//   Channel   Direction  Handshake                   Payload
//   s_axis    in         s_axis_tvalid/tready        tuser: restart, tdata: mix_in
//   m_axis    out        m_axis_tvalid/tready        tdata: mix_out, tuser: active,
//                                                    tlast: last
//   apb       in         psel/penable/pwrite/pready  registers at 8-byte strides
//
// One item per clock sustained while the result side is not stalled; an accepted item passes
// through the input register, then the result register, before it leaves.
// The loop through the step register and the 20x32 partial-product sweep multiplier
// sets the clock period.
// Synchronous reset empties both registers and stops the tone; no clearing pass.
// A stalled result holds in place while the input register still takes one more item.
module swept_square_wave_mixer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,  // [15:0] mix_in
  input  logic [0:0]                     s_axis_tuser,  // [0] restart
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,  // [15:0] mix_out
  output logic [0:0]                     m_axis_tuser,  // [0] active
  output logic                           m_axis_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [smx_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [smx_pkg::APB_DATA_W-1:0] pwdata,
  output logic [smx_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import smx_pkg::*;

  cfg_t    cfg;
  tick_t   in_reg;
  logic    in_valid;
  result_t out_reg;
  logic    out_valid;
  result_t tone_res;
  logic    tone_running;
  logic    advance;

  smx_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Move an item on when the result register is free or being drained
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_reg.restart <= s_axis_tuser[0];
      in_reg.mix_in  <= $signed(s_axis_tdata);
    end
  end

  smx_tone u_tone (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_reg),
    .cfg     (cfg),
    .res     (tone_res),
    .running (tone_running)
  );

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= tone_res;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = $unsigned(out_reg.mix_out);
  assign m_axis_tuser[0] = out_reg.active;
  assign m_axis_tlast    = out_reg.last;

  // A final sample leaves the tone stopped
  assert property (@(posedge clk) disable iff (rst)
    advance && tone_res.last |=> !tone_running)
    else $error("tone still running after its final sample");

  // With no tone and no restart the sample passes through untouched
  assert property (@(posedge clk) disable iff (rst)
    advance && !tone_running && !in_reg.restart |->
      !tone_res.active && (tone_res.mix_out == in_reg.mix_in))
    else $error("idle sample was altered");

  // A final-sample mark only comes with an active sample
  assert property (@(posedge clk) disable iff (rst)
    advance && tone_res.last |-> tone_res.active)
    else $error("final-sample mark on an inactive sample");

  // An empty input register always takes an item
  assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_axis_tready)
    else $error("input stalled while input register empty");

endmodule

// ===== sim/tb_swept_square_wave_mixer_unit.sv =====
// Testbench for swept_square_wave_mixer_unit: stream-in ticks, stream-out mixed samples.
// Depends on smx_pkg and the RTL; predicts every result in a scoreboard class and checks
// each one in order, while both stream sides idle at random.
`timescale 1ns / 100ps

module tb_swept_square_wave_mixer_unit;
  import smx_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 90;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
  localparam logic [STEP_W-1:0] STEP_SAT = '1;
  localparam logic [FACTOR_W-1:0] SWEEP_UNITY = 32'h4000_0000;

  // Tone model plus expected-result store
  class smx_tone_scoreboard;
    cfg_t cfg;
    logic [PHASE_BITS-1:0] phase;
    logic [STEP_W-1:0] step_now;
    logic [COUNT_BITS-1:0] samples_done;
    bit running;
    result_t expected_q[$];
    int errors;

    function new();
      cfg.start_step = START_STEP_RST;
      cfg.sweep_factor = SWEEP_FACTOR_RST;
      cfg.duty = DUTY_RST;
      cfg.volume = VOLUME_RST;
      cfg.sample_count = SAMPLE_COUNT_RST;
      phase = '0;
      step_now = '0;
      samples_done = '0;
      running = 0;
      errors = 0;
    endfunction

    // Mirror a register write; unmapped indexes drop, values mask to width
    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
      case (idx)
        REG_START_STEP:   cfg.start_step = value[STEP_W-1:0];
        REG_SWEEP_FACTOR: cfg.sweep_factor = value[FACTOR_W-1:0];
        REG_DUTY:         cfg.duty = value[DUTY_W-1:0];
        REG_VOLUME:       cfg.volume = value[VOL_W-1:0];
        REG_SAMPLE_COUNT: cfg.sample_count = value[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the tone by one accepted tick and queue the mixed sample
    function void note_tick(tick_t t);
      result_t r;
      logic [15:0] vol16;
      logic [15:0] level;
      logic [15:0] top;
      logic [71:0] prod;
      logic [71:0] swept;
      r.mix_out = t.mix_in;
      r.active = 1'b0;
      r.last = 1'b0;
      if (t.restart) begin
        phase = '0;
        step_now = cfg.start_step;
        samples_done = '0;
        running = (cfg.sample_count != '0);
      end
      if (running) begin
        phase = phase + step_now[31 -: PHASE_BITS];
        top = phase[PHASE_BITS-1 -: 16];
        vol16 = {1'b0, cfg.volume};
        level = ({1'b0, top} < cfg.duty) ? (16'd0 - vol16) : vol16;
        r.mix_out = t.mix_in + level;
        // sweep the step: UQ8.32 times UQ2.30, truncate, saturate
        prod = 72'(step_now) * 72'(cfg.sweep_factor);
        swept = prod >> 30;
        step_now = (|swept[71:STEP_W]) ? STEP_SAT : swept[STEP_W-1:0];
        samples_done = samples_done + 1'b1;
        r.active = 1'b1;
        if (samples_done == '0 || samples_done >= cfg.sample_count) begin
          r.last = 1'b1;
          running = 0;
        end
      end
      expected_q.push_back(r);
    endfunction

    // Compare one output item with the oldest expected sample
    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected output item: mix_out %0d active %0d last %0d",
               got.mix_out, got.active, got.last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.mix_out !== want.mix_out) begin
        $error("mix_out expected %0d actual %0d", want.mix_out, got.mix_out);
        errors++;
      end
      if (got.active !== want.active) begin
        $error("active expected %0d actual %0d", want.active, got.active);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last expected %0d actual %0d", want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] mix_in
  logic [0:0] s_axis_tuser;    // [0] restart
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [15:0] m_axis_tdata;   // [15:0] mix_out
  logic [0:0] m_axis_tuser;    // [0] active
  logic m_axis_tlast;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  smx_tone_scoreboard sb;
  int cycle_count = 0;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_req = 0;

  swept_square_wave_mixer_unit dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_swept_square_wave_mixer_unit: FAIL");
      $finish;
    end
  end

  // Check every output item taken
  always @(posedge clk) begin
    result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.mix_out = m_axis_tdata;
      got.active = m_axis_tuser[0];
      got.last = m_axis_tlast;
      sb.check_result(got);
    end
  end

  // Mostly short idle stretches, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        m_axis_tready = 1'b0;
        repeat (rx_hold_req) @(negedge clk);
        rx_hold_req = 0;
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        m_axis_tready = 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Register write: setup cycle, then access cycle until pready
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = APB_ADDR_W'(idx) << 3;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_config(input logic [APB_DATA_W-1:0] start, input logic [APB_DATA_W-1:0] sweep,
                            input logic [APB_DATA_W-1:0] duty, input logic [APB_DATA_W-1:0] vol,
                            input logic [APB_DATA_W-1:0] count);
    apb_write(REG_START_STEP, start);
    apb_write(REG_SWEEP_FACTOR, sweep);
    apb_write(REG_DUTY, duty);
    apb_write(REG_VOLUME, vol);
    apb_write(REG_SAMPLE_COUNT, count);
  endtask

  // Offer one tick, called at a falling edge; returns at the falling edge after acceptance
  task automatic send_tick(input logic restart, input logic [15:0] mix);
    tick_t t;
    if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      s_axis_tvalid = 1'b0;
      repeat (pick_gap()) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = mix;
    s_axis_tuser = restart;
    do @(posedge clk); while (!s_axis_tready);
    t.restart = restart;
    t.mix_in = mix;
    sb.note_tick(t);
    @(negedge clk);
  endtask

  // Stop offering, wait for every expected item, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Field value with random junk above its width half of the time
  function automatic logic [APB_DATA_W-1:0] with_junk(logic [APB_DATA_W-1:0] field, int width);
    logic [APB_DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) return field;
    return field | (junk << width);
  endfunction

  function automatic logic [15:0] pick_mix();
    case ($urandom_range(0, 19))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random register set, extremes weighted in
  task automatic random_config();
    logic [APB_DATA_W-1:0] start;
    logic [APB_DATA_W-1:0] sweep;
    logic [APB_DATA_W-1:0] duty;
    logic [APB_DATA_W-1:0] vol;
    logic [APB_DATA_W-1:0] count;
    case ($urandom_range(0, 4))
      0: start = '0;
      1: start = {24'd0, STEP_SAT};
      2: start = {$urandom, $urandom} & 64'hFF_FFFF_FFFF;
      default: start = 64'($urandom_range(0, 32'h1000_0000));
    endcase
    case ($urandom_range(0, 5))
      0: sweep = '0;
      1: sweep = 64'hFFFF_FFFF;
      2: sweep = 64'(SWEEP_UNITY);
      3: sweep = 64'($urandom);
      default: sweep = 64'(SWEEP_UNITY) + 64'($urandom_range(0, 32'h0010_0000))
                       - 64'h8_0000;
    endcase
    case ($urandom_range(0, 5))
      0: duty = '0;
      1: duty = 64'd65536;
      2: duty = 64'h1FFFF;
      default: duty = 64'($urandom_range(0, 32'h1FFFF));
    endcase
    case ($urandom_range(0, 3))
      0: vol = '0;
      1: vol = 64'h7FFF;
      default: vol = 64'($urandom_range(0, 32'h7FFF));
    endcase
    case ($urandom_range(0, 9))
      0: count = '0;
      1: count = 64'd1;
      2: count = 64'hF_FFFF;
      3: count = 64'($urandom_range(0, 32'hF_FFFF));
      default: count = 64'($urandom_range(1, 40));
    endcase
    set_config(with_junk(start, STEP_W), with_junk(sweep, FACTOR_W), with_junk(duty, DUTY_W),
               with_junk(vol, VOL_W), with_junk(count, LEN_W));
    apb_write(REG_UNMAPPED_LO + REG_IDX_W'($urandom_range(0, 2)), {$urandom, $urandom});
  endtask

  initial begin
    logic quiet;
    sb = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset config: zero length, so a restart passes the sample through
    send_tick(1'b1, 16'h8000);
    send_tick(1'b0, 16'h7FFF);
    drain();

    // Quarter-cycle step at full volume, restart in the middle of the tone
    set_config(64'h4000_0000, 64'(SWEEP_UNITY), 64'd32768, 64'h7FFF, 64'd4);
    send_tick(1'b1, 16'h7FFF);
    send_tick(1'b0, 16'h8000);
    send_tick(1'b0, 16'h0000);
    send_tick(1'b1, 16'h1234);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b0, 16'h8001);
    send_tick(1'b0, 16'h7FFE);
    send_tick(1'b0, 16'h5555);
    drain();

    // Saturating sweep from the largest step, duty above full scale
    set_config({24'd0, STEP_SAT}, 64'hFFFF_FFFF, 64'h1FFFF, 64'h7FFF, 64'd3);
    send_tick(1'b1, 16'h0000);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b0, 16'h8000);
    drain();

    // Zero duty keeps the level high; zero sweep kills the step
    set_config(64'h01_0000_0001, 64'd0, 64'd0, 64'h2AAA, 64'd3);
    send_tick(1'b1, 16'h7FFF);
    send_tick(1'b0, 16'hAAAA);
    send_tick(1'b0, 16'h0001);
    drain();

    // Long tone, then the length is cut below the samples already played
    set_config(64'h1000_0000, 64'(SWEEP_UNITY) + 64'd1000, 64'd40000, 64'h1234, 64'd1000);
    send_tick(1'b1, 16'h0100);
    repeat (5) send_tick(1'b0, pick_mix());
    drain();
    apb_write(REG_SAMPLE_COUNT, 64'd2);
    send_tick(1'b0, 16'h7000);
    send_tick(1'b0, 16'h9000);
    drain();

    // Random phases; every third phase runs without random idling; phase 4 holds the receiver off once
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      quiet = (p % 3 == 1);
      tx_gap_pct = quiet ? 0 : 25;
      rx_stall_pct = quiet ? 0 : 25;
      random_config();
      if (p == 4) begin
        tx_gap_pct = 0;
        rx_hold_req = LONG_HOLD_CYCLES;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i == 0)
          send_tick($urandom_range(0, 9) < 7, pick_mix());
        else
          send_tick($urandom_range(0, 99) < 6, pick_mix());
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("tb_swept_square_wave_mixer_unit: PASS");
    else
      $display("tb_swept_square_wave_mixer_unit: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/smx_pkg.sv
src/smx_apb_regs.sv
src/smx_sweep_mul.sv
src/smx_tone.sv
src/swept_square_wave_mixer_unit.sv
sim/tb_swept_square_wave_mixer_unit.sv
